FILE: rtl/ebc_pkg.sv
// Shared widths, register codes, reset values and phase tables for the commutator.
package ebc_pkg;

  localparam int ANGLE_W   = 14;
  localparam int DUTY_W    = 11;
  localparam int SECTOR_W  = 14;
  localparam int HALF_W    = 13;
  localparam int SEC_IDX_W = 3;
  localparam int PHASE_W   = 2;
  localparam int DRIVE_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 14;

  localparam int ENCODER_LINES_DEF = 16384;
  localparam int DUTY_LIMIT        = 950;

  // largest distance between an angle and the shifted reference point
  localparam int REF_SPAN = (2 ** ANGLE_W - 1) + (2 ** HALF_W - 1);

  localparam int SECTORS = 6;
  localparam int FWD_ADJ = 1;
  // minus three is plus three modulo six
  localparam int REV_ADJ = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_W   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SEC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REV_TABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 3'd4;

  localparam logic [ANGLE_W-1:0]  START_POS_RST = 14'd13406;
  localparam logic [SECTOR_W-1:0] SECTOR_W_RST  = 14'd390;
  localparam logic [HALF_W-1:0]   HALF_SEC_RST  = 13'd195;

  localparam logic [PHASE_W-1:0] PH_A = 2'd0;
  localparam logic [PHASE_W-1:0] PH_B = 2'd1;
  localparam logic [PHASE_W-1:0] PH_C = 2'd2;

  typedef struct packed {
    logic [PHASE_W-1:0] high;
    logic [PHASE_W-1:0] low;
  } phase_pair_t;

  function automatic phase_pair_t phase_lookup(input logic rev,
                                               input logic [SEC_IDX_W-1:0] sec);
    phase_pair_t p;
    p = '{high: PH_A, low: PH_A};
    if (!rev) begin
      case (sec)
        3'd0: p = '{high: PH_A, low: PH_B};
        3'd1: p = '{high: PH_A, low: PH_C};
        3'd2: p = '{high: PH_B, low: PH_C};
        3'd3: p = '{high: PH_B, low: PH_A};
        3'd4: p = '{high: PH_C, low: PH_A};
        3'd5: p = '{high: PH_C, low: PH_B};
        default: p = '{high: PH_A, low: PH_A};
      endcase
    end else begin
      case (sec)
        3'd0: p = '{high: PH_C, low: PH_A};
        3'd1: p = '{high: PH_B, low: PH_A};
        3'd2: p = '{high: PH_B, low: PH_C};
        3'd3: p = '{high: PH_A, low: PH_C};
        3'd4: p = '{high: PH_A, low: PH_B};
        3'd5: p = '{high: PH_C, low: PH_B};
        default: p = '{high: PH_A, low: PH_A};
      endcase
    end
    return p;
  endfunction

endpackage

FILE: rtl/ebc_if.sv
// Valid/ready channel interfaces for encoder requests and commutation results.
interface ebc_in_if import ebc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       encoder_angle;
  logic signed [DUTY_W-1:0] duty_command;

  modport source (output valid, encoder_angle, duty_command, input ready);
  modport sink   (input valid, encoder_angle, duty_command, output ready);
endinterface

interface ebc_out_if import ebc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 commutate;
  logic [SEC_IDX_W-1:0] sector_now;
  logic [PHASE_W-1:0]   high_phase;
  logic [PHASE_W-1:0]   low_phase;
  logic [DRIVE_W-1:0]   drive_duty;

  modport source (output valid, commutate, sector_now, high_phase, low_phase, drive_duty,
                  input ready);
  modport sink   (input valid, commutate, sector_now, high_phase, low_phase, drive_duty,
                  output ready);
endinterface

FILE: rtl/encoder_bldc_commutator_top.sv
// Six-step commutator: encoder angle to sector, phases and clamped duty.
//
//   port    dir  handshake        payload
//   in_ch   in   valid/ready      encoder_angle, duty_command
//   out_ch  out  valid/ready      commutate, sector_now, high_phase, low_phase, drive_duty
//   cfg_*   in   cfg_we only      cfg_index, cfg_wdata
//
// The angle difference is wrapped modulo ENCODER_LINES by a reciprocal multiply and
// one correction subtract. One restoring divider then takes DW steps for the sector
// width, reducing the quotient modulo six bit by bit as it goes. A request is taken
// only in the idle state, so the next one waits until the sequencer has left ST_FIN.
// A new request is taken while a result still waits in the output register; a
// stalled result holds the sequencer in its final state. Synchronous reset
// restores the register defaults and clears the latched sector and duty.
module encoder_bldc_commutator_top import ebc_pkg::*; #(
  parameter int ENCODER_LINES = ENCODER_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ebc_in_if.sink               in_ch,
  ebc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // offset that keeps the wrapped difference non-negative
  localparam int OFF  = ((REF_SPAN + ENCODER_LINES - 1) / ENCODER_LINES) * ENCODER_LINES;
  localparam int VMAX = REF_SPAN + OFF;
  localparam int DW   = $clog2(VMAX + 1);
  localparam int DVW  = SECTOR_W;
  localparam int CW   = $clog2(DW);
  // floor(2^DW / lines): the quotient estimate is at most one below the true one
  localparam int RM   = (2 ** DW) / ENCODER_LINES;
  localparam int RMW  = $clog2(RM + 1);
  localparam int PW   = DW + RMW;
  localparam int R6W  = SEC_IDX_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODL,
    ST_DIVW,
    ST_FIN
  } state_t;

  state_t state_r;

  logic [ANGLE_W-1:0]  start_pos_r;
  logic [SECTOR_W-1:0] sector_width_r;
  logic [HALF_W-1:0]   half_sec_r;
  logic                rev_table_r;
  logic                run_enable_r;

  logic [SEC_IDX_W-1:0] last_sector_r;
  logic [DRIVE_W-1:0]   applied_duty_r;

  logic [DW-1:0]        div_r;
  logic [DVW-1:0]       rem_r;
  logic [DVW-1:0]       dvs_r;
  logic [CW-1:0]        cnt_r;
  logic [SEC_IDX_W-1:0] r6_r;
  logic                 fwd_r;
  logic [DRIVE_W-1:0]   mag_r;

  logic                 out_valid_r;
  logic                 out_commutate_r;
  logic [SEC_IDX_W-1:0] out_sector_r;
  logic [PHASE_W-1:0]   out_high_r;
  logic [PHASE_W-1:0]   out_low_r;
  logic [DRIVE_W-1:0]   out_duty_r;

  // divider step
  logic [DVW:0]    trial;
  logic            qbit;
  logic [DVW:0]    rem_diff;
  logic [DVW-1:0]  rem_step;
  logic [DW-1:0]   quot_step;

  // quotient modulo six, one quotient bit per step
  logic [R6W-1:0]       r6_dbl;
  logic [R6W-1:0]       r6_sub;
  logic [SEC_IDX_W-1:0] r6_step;
  logic [R6W-1:0]       sec_sum;
  logic [R6W-1:0]       sec_sub;
  logic [SEC_IDX_W-1:0] sector_calc;

  // request setup
  logic               fwd_in;
  logic [DW-1:0]      base_in;
  logic [DW-1:0]      v_init;
  logic [DUTY_W-1:0]  duty_abs;
  logic [DRIVE_W-1:0] mag_in;
  logic [DVW-1:0]     width_eff;
  logic [R6W-1:0]     sec_adj;

  // wrap modulo the line count
  logic [PW-1:0]  wrap_prod;
  logic [RMW-1:0] wrap_q;
  logic [DW-1:0]  wrap_r;
  logic [DW-1:0]  wrap_diff;

  // commit
  logic [SEC_IDX_W-1:0] sector_new;
  logic                 commit;
  logic [SEC_IDX_W-1:0] last_sector_nxt;
  logic [DRIVE_W-1:0]   applied_duty_nxt;
  phase_pair_t          phases_nxt;
  logic                 out_free;

  always_comb begin
    trial     = {rem_r, div_r[DW-1]};
    qbit      = (trial >= {1'b0, dvs_r});
    rem_diff  = trial - {1'b0, dvs_r};
    rem_step  = qbit ? rem_diff[DVW-1:0] : trial[DVW-1:0];
    quot_step = {div_r[DW-2:0], qbit};

    r6_dbl      = {r6_r, qbit};
    r6_sub      = r6_dbl - R6W'(SECTORS);
    r6_step     = (r6_dbl >= R6W'(SECTORS)) ? r6_sub[SEC_IDX_W-1:0] : r6_dbl[SEC_IDX_W-1:0];
    sec_sum     = R6W'(r6_step) + sec_adj;
    sec_sub     = sec_sum - R6W'(SECTORS);
    sector_calc = (sec_sum >= R6W'(SECTORS)) ? sec_sub[SEC_IDX_W-1:0]
                                             : sec_sum[SEC_IDX_W-1:0];
  end

  always_comb begin
    fwd_in  = in_ch.duty_command[DUTY_W-1];
    base_in = DW'(in_ch.encoder_angle) + DW'(OFF) - DW'(start_pos_r);
    v_init  = fwd_in ? (base_in - DW'(half_sec_r)) : (base_in + DW'(half_sec_r));
    // magnitude of the most negative code fits as an unsigned value
    duty_abs = fwd_in ? (~in_ch.duty_command + 1'b1) : in_ch.duty_command;
    mag_in   = (duty_abs > DUTY_W'(DUTY_LIMIT)) ? DRIVE_W'(DUTY_LIMIT)
                                                  : duty_abs[DRIVE_W-1:0];
    width_eff = (sector_width_r == '0) ? DVW'(1) : DVW'(sector_width_r);
    sec_adj   = fwd_r ? R6W'(FWD_ADJ) : R6W'(REV_ADJ);

    wrap_prod = PW'(div_r) * PW'(RM);
    wrap_q    = wrap_prod[PW-1:DW];
    wrap_r    = div_r - DW'(wrap_q) * DW'(ENCODER_LINES);
    wrap_diff = (wrap_r >= DW'(ENCODER_LINES)) ? (wrap_r - DW'(ENCODER_LINES)) : wrap_r;
  end

  always_comb begin
    sector_new       = rem_r[SEC_IDX_W-1:0];
    commit           = run_enable_r && (sector_new != last_sector_r);
    last_sector_nxt  = commit ? sector_new : last_sector_r;
    applied_duty_nxt = commit ? mag_r : applied_duty_r;
    phases_nxt       = phase_lookup(rev_table_r, last_sector_nxt);
    out_free         = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      start_pos_r    <= START_POS_RST;
      sector_width_r <= SECTOR_W_RST;
      half_sec_r     <= HALF_SEC_RST;
      rev_table_r    <= 1'b0;
      run_enable_r   <= 1'b1;
      last_sector_r  <= '0;
      applied_duty_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_POS:  start_pos_r    <= cfg_wdata[ANGLE_W-1:0];
          REG_SECTOR_W:   sector_width_r <= cfg_wdata[SECTOR_W-1:0];
          REG_HALF_SEC:   half_sec_r     <= cfg_wdata[HALF_W-1:0];
          REG_REV_TABLE:  rev_table_r    <= cfg_wdata[0];
          REG_RUN_ENABLE: run_enable_r   <= cfg_wdata[0];
          default: ;
        endcase
      end

      // in the final state the result register is reloaded instead
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            div_r   <= v_init;
            fwd_r   <= fwd_in;
            mag_r   <= mag_in;
            state_r <= ST_MODL;
          end
        end
        ST_MODL: begin
          // wrapped difference becomes the dividend of the sector-width pass
          div_r   <= wrap_diff;
          rem_r   <= '0;
          r6_r    <= '0;
          dvs_r   <= width_eff;
          cnt_r   <= CW'(DW - 1);
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          div_r <= quot_step;
          r6_r  <= r6_step;
          if (cnt_r == '0) begin
            // sector waits in the remainder register until it is committed
            rem_r   <= DVW'(sector_calc);
            state_r <= ST_FIN;
          end else begin
            rem_r <= rem_step;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            last_sector_r   <= last_sector_nxt;
            applied_duty_r  <= applied_duty_nxt;
            out_valid_r     <= 1'b1;
            out_commutate_r <= commit;
            out_sector_r    <= last_sector_nxt;
            out_high_r      <= phases_nxt.high;
            out_low_r       <= phases_nxt.low;
            out_duty_r      <= applied_duty_nxt;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.commutate  = out_commutate_r;
  assign out_ch.sector_now = out_sector_r;
  assign out_ch.high_phase = out_high_r;
  assign out_ch.low_phase  = out_low_r;
  assign out_ch.drive_duty = out_duty_r;

endmodule
